// ===== hdl/chtp_pkg.sv =====
// shared constants and codes for the chained hash table probe counter
package chtp_pkg;

  localparam int KEY_W     = 16;
  localparam int CNT_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int ACTION_W  = 2;
  localparam int COMP_W    = 6;
  localparam int BUCKET_W  = 6;
  localparam int STEP_W    = $clog2(KEY_W + 1);

  localparam int DEF_NUM_BUCKETS = 64;
  localparam int DEF_CHAIN_DEPTH = 32;

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd10;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

endpackage

// ===== hdl/chained_hash_table_probe_count.sv =====
// chained hash table top level: bucket lengths and chain keys in memories, walk per search
//
//  channel | ports                                            | transfer
//  --------+--------------------------------------------------+-------------------------
//  input   | start, busy, in_action, in_key                   | start high, busy low
//  result  | out_valid, out_status, out_comparisons, out_bucket| out_valid high, one cycle
//  config  | cfg_we, cfg_wdata                                | cfg_we high
//
//  insert or unused action: the remainder in chtp_mod, then S_LRD reads the length and S_DEC decides;
//    the result is registered out of S_DEC
//  search: the same steps, then S_WALK compares the stored keys in order until a match or the
//    end of the chain; an empty chain ends in S_DEC
//  clear: S_INIT sweeps the length memory bucket by bucket, then the result shows
//  after reset the same sweep runs with busy high
//  busy falls as the result shows; the receiver cannot stall
module chained_hash_table_probe_count #(
  parameter int NUM_BUCKETS = chtp_pkg::DEF_NUM_BUCKETS,
  parameter int CHAIN_DEPTH = chtp_pkg::DEF_CHAIN_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [chtp_pkg::ACTION_W-1:0] in_action,
  input  logic [chtp_pkg::KEY_W-1:0]    in_key,
  output logic                          out_valid,
  output logic [chtp_pkg::STATUS_W-1:0] out_status,
  output logic [chtp_pkg::COMP_W-1:0]   out_comparisons,
  output logic [chtp_pkg::BUCKET_W-1:0] out_bucket,
  input  logic                          cfg_we,
  input  logic [chtp_pkg::CNT_W-1:0]    cfg_wdata
);
  import chtp_pkg::*;

  localparam int BW      = $clog2(NUM_BUCKETS);
  localparam int IW      = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int LW      = $clog2(CHAIN_DEPTH + 1);
  localparam int KDEPTH  = NUM_BUCKETS * (1 << IW);
  localparam int CNT_MAX = (NUM_BUCKETS < 127) ? NUM_BUCKETS : 127;
  localparam logic [CNT_W-1:0] CNT_MAX_V = CNT_W'(CNT_MAX);
  localparam logic [LW-1:0]    DEPTH_V   = LW'(CHAIN_DEPTH);
  localparam logic [BW-1:0]    LAST_B    = BW'(NUM_BUCKETS - 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_LRD  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_WALK = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    eff_count;
  logic [ACTION_W-1:0] action_r, action_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [BW-1:0]       bucket_r, bucket_nxt;
  logic [BW-1:0]       clr_idx_r, clr_idx_nxt;
  logic                clr_emit_r, clr_emit_nxt;
  logic [LW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [LW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [LW-1:0]       out_comp_r, out_comp_nxt;
  logic [BW-1:0]       out_bucket_r, out_bucket_nxt;

  logic [LW-1:0]       len_mem [NUM_BUCKETS];
  logic [LW-1:0]       len_q_r;
  logic                len_we;
  logic [BW-1:0]       len_waddr;
  logic [LW-1:0]       len_wdata;

  logic [KEY_W-1:0]    key_mem [KDEPTH];
  logic [KEY_W-1:0]    key_q_r;
  logic                key_we;

  logic                mod_start;
  logic                mod_done;
  logic [CNT_W-1:0]    mod_rem;

  always_comb begin
    eff_count = count_r;
    if (eff_count == '0) begin
      eff_count = CNT_W'(1);
    end
    if (eff_count > CNT_MAX_V) begin
      eff_count = CNT_MAX_V;
    end
  end

  chtp_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_key),
    .divisor  (eff_count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    action_nxt     = action_r;
    key_nxt        = key_r;
    bucket_nxt     = bucket_r;
    clr_idx_nxt    = clr_idx_r;
    clr_emit_nxt   = clr_emit_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_comp_nxt   = out_comp_r;
    out_bucket_nxt = out_bucket_r;
    len_we         = 1'b0;
    len_waddr      = bucket_r;
    len_wdata      = len_q_r + 1'b1;
    key_we         = 1'b0;
    mod_start      = 1'b0;
    case (state_r)
      S_INIT: begin
        len_we      = 1'b1;
        len_waddr   = clr_idx_r;
        len_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_B) begin
          state_nxt    = S_IDLE;
          clr_emit_nxt = 1'b0;
          if (clr_emit_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_comp_nxt   = '0;
            out_bucket_nxt = '0;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          action_nxt = in_action;
          key_nxt    = in_key;
          if (in_action == ACT_CLEAR) begin
            state_nxt    = S_INIT;
            clr_idx_nxt  = '0;
            clr_emit_nxt = 1'b1;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          bucket_nxt = BW'(mod_rem);
          state_nxt  = S_LRD;
        end
      end
      S_LRD: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        out_bucket_nxt = bucket_r;
        out_comp_nxt   = '0;
        out_status_nxt = ST_OK;
        state_nxt      = S_IDLE;
        case (action_r)
          ACT_INSERT: begin
            out_valid_nxt = 1'b1;
            if (len_q_r >= DEPTH_V) begin
              out_status_nxt = ST_FULL;
            end else begin
              key_we = 1'b1;
              len_we = 1'b1;
            end
          end
          ACT_SEARCH: begin
            if (len_q_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_NOT_FOUND;
            end else begin
              rd_idx_nxt = '0;
              state_nxt  = S_WALK;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end
      S_WALK: begin
        if (rd_idx_r < len_q_r) begin
          rd_idx_nxt  = rd_idx_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
        end
        if (cmp_vld_r) begin
          if (key_q_r == key_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_comp_nxt   = cmp_idx_r + 1'b1;
            state_nxt      = S_IDLE;
            cmp_vld_nxt    = 1'b0;
          end else if (cmp_idx_r + 1'b1 == len_q_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOT_FOUND;
            out_comp_nxt   = len_q_r;
            state_nxt      = S_IDLE;
            cmp_vld_nxt    = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (state_r == S_IDLE && start && in_action != ACT_CLEAR) begin
      mod_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_q_r <= len_mem[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[{bucket_r, len_q_r[IW-1:0]}] <= key_r;
    end
    key_q_r <= key_mem[{bucket_r, rd_idx_r[IW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CNT_RESET;
      clr_idx_r   <= '0;
      clr_emit_r  <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_emit_r  <= clr_emit_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
    action_r     <= action_nxt;
    key_r        <= key_nxt;
    bucket_r     <= bucket_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    out_status_r <= out_status_nxt;
    out_comp_r   <= out_comp_nxt;
    out_bucket_r <= out_bucket_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_comparisons = COMP_W'(out_comp_r);
  assign out_bucket      = BUCKET_W'(out_bucket_r);

endmodule

// ===== hdl/chtp_mod.sv =====
// iterative restoring remainder of the key by the bucket count, one bit per cycle
module chtp_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [chtp_pkg::KEY_W-1:0] dividend,
  input  logic [chtp_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [chtp_pkg::CNT_W-1:0] rem
);
  import chtp_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [KEY_W-1:0]    dvd_r, dvd_nxt;
  logic [CNT_W-1:0]    dvs_r, dvs_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W:0]      shl;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    shl      = {rem_r, dvd_r[KEY_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(KEY_W);
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (shl >= {1'b0, dvs_r}) begin
        rem_nxt = CNT_W'(shl - {1'b0, dvs_r});
      end else begin
        rem_nxt = CNT_W'(shl);
      end
      dvd_nxt = {dvd_r[KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== tb/chained_hash_table_probe_count_tb.sv =====
// self-checking testbench for the chained hash table probe counter
module chained_hash_table_probe_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chtp_pkg::*;

  localparam int NUM_BKT        = DEF_NUM_BUCKETS;
  localparam int DEPTH          = DEF_CHAIN_DEPTH;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COMP_W-1:0]   comps;
    logic [BUCKET_W-1:0] bucket;
  } probe_result_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  logic [ACTION_W-1:0] in_action = ACT_INSERT;
  logic [KEY_W-1:0]    in_key    = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [COMP_W-1:0]   out_comparisons;
  logic [BUCKET_W-1:0] out_bucket;
  logic                cfg_we    = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata = '0;

  // table model
  logic [CNT_W-1:0] bucket_count_q = CNT_RESET;
  int unsigned      chain_len [NUM_BKT];
  logic [KEY_W-1:0] chain_key [NUM_BKT][DEPTH];
  logic [KEY_W-1:0] stored_keys [$];

  probe_result_t pending_results [$];
  int            mismatch_cnt;
  int            quiet_cycles;
  int            action_cnt [4];
  int            found_cnt;
  int            full_cnt;
  int            longest_walk;
  int            count_writes;

  chained_hash_table_probe_count u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_comparisons (out_comparisons),
    .out_bucket      (out_bucket),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned hash_divisor();
    int unsigned divisor;
    divisor = bucket_count_q;
    if (divisor == 0) divisor = 1;
    if (divisor > NUM_BKT) divisor = NUM_BKT;
    return divisor;
  endfunction

  function automatic probe_result_t apply_table_op(input logic [ACTION_W-1:0] action,
                                                   input logic [KEY_W-1:0] key);
    int unsigned   bkt;
    int unsigned   len;
    bit            hit;
    probe_result_t res;
    bkt        = key % hash_divisor();
    len        = chain_len[bkt];
    hit        = 1'b0;
    res.status = ST_OK;
    res.comps  = '0;
    res.bucket = BUCKET_W'(bkt);
    case (action)
      ACT_INSERT: begin
        if (len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          chain_key[bkt][len] = key;
          chain_len[bkt]      = len + 1;
        end
      end
      ACT_SEARCH: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < len && !hit; i++) begin
          res.comps = COMP_W'(i + 1);
          if (chain_key[bkt][i] == key) begin
            res.status = ST_OK;
            hit        = 1'b1;
          end
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < NUM_BKT; i++) chain_len[i] = 0;
        res.bucket = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap(input int idle_pct);
    if ($urandom_range(99) < idle_pct) return $urandom_range(1, 60);
    return 0;
  endfunction

  function automatic logic [CNT_W-1:0] CNT_WIDTH_VAL(input int unsigned v);
    return CNT_W'(v);
  endfunction

  task automatic send_op(input logic [ACTION_W-1:0] action, input logic [KEY_W-1:0] key,
                         input int gap);
    probe_result_t want;
    start     <= 1'b1;
    in_action <= action;
    in_key    <= key;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    want = apply_table_op(action, key);
    pending_results.push_back(want);
    action_cnt[action]++;
    if (action == ACT_SEARCH && want.status == ST_OK) found_cnt++;
    if (want.status == ST_FULL) full_cnt++;
    if (want.comps > longest_walk) longest_walk = want.comps;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [CNT_W-1:0] value);
    wait_drained();
    while (busy !== 1'b0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    bucket_count_q  = value;
    count_writes++;
  endtask

  task automatic run_random_ops(input int n_ops, input int ins_pct, input int idle_pct);
    int                  r;
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    key;
    for (int n = 0; n < n_ops; n++) begin
      r   = $urandom_range(99);
      key = KEY_W'($urandom_range(0, 65535));
      if (r < 1) begin
        act = ACT_CLEAR;
        stored_keys.delete();
      end else if (r < 3) begin
        act = ACT_NONE;
      end else if (r < 3 + ins_pct) begin
        act = ACT_INSERT;
        if (stored_keys.size() > 0 && $urandom_range(99) < 25)
          key = stored_keys[$urandom_range(stored_keys.size() - 1)];
        stored_keys.push_back(key);
        if (stored_keys.size() > 512) void'(stored_keys.pop_front());
      end else begin
        act = ACT_SEARCH;
        if (stored_keys.size() > 0 && $urandom_range(99) < 75) begin
          key = stored_keys[$urandom_range(stored_keys.size() - 1)];
          // same bucket, usually a miss that walks the whole chain
          if ($urandom_range(99) < 25) key = key + KEY_W'(hash_divisor());
        end
      end
      send_op(act, key, pick_gap(idle_pct));
    end
  endtask

  task automatic test_reset_defaults();
    send_op(ACT_INSERT, 16'd0, 0);
    send_op(ACT_INSERT, 16'hffff, 0);
    send_op(ACT_INSERT, 16'd10, 0);
    send_op(ACT_INSERT, 16'd0, 0);
    send_op(ACT_SEARCH, 16'd0, 0);
    send_op(ACT_SEARCH, 16'd10, 0);
    send_op(ACT_SEARCH, 16'd20, 0);
    send_op(ACT_SEARCH, 16'hffff, 0);
    send_op(ACT_SEARCH, 16'd5, 0);
    send_op(ACT_SEARCH, 16'd1, 0);
    send_op(ACT_NONE, 16'h5a5a, 0);
    send_op(ACT_CLEAR, 16'hffff, 0);
    send_op(ACT_SEARCH, 16'd0, 0);
  endtask

  task automatic test_count_extremes();
    write_bucket_count(7'd0);
    send_op(ACT_INSERT, 16'd12345, 0);
    send_op(ACT_SEARCH, 16'd12345, 0);
    write_bucket_count(7'd127);
    send_op(ACT_INSERT, 16'd63, 0);
    send_op(ACT_INSERT, 16'hffff, 0);
    send_op(ACT_SEARCH, 16'hffff, 0);
    write_bucket_count(7'd64);
    send_op(ACT_SEARCH, 16'd63, 0);
    write_bucket_count(7'd65);
    send_op(ACT_INSERT, 16'd127, 0);
    send_op(ACT_SEARCH, 16'd127, 0);
    // keys stay put while the hash moves
    write_bucket_count(7'd10);
    send_op(ACT_SEARCH, 16'd63, 0);
  endtask

  task automatic test_chain_overflow();
    write_bucket_count(7'd1);
    run_random_ops(250, 60, 0);
  endtask

  task automatic test_wide_table();
    write_bucket_count(7'd64);
    run_random_ops(150, 50, 75);
    // hold off until the block has nothing outstanding
    wait_drained();
    run_random_ops(150, 50, 0);
  endtask

  task automatic test_narrow_table();
    write_bucket_count(7'd7);
    run_random_ops(300, 50, 35);
  endtask

  task automatic test_saturated_count();
    write_bucket_count(7'd127);
    run_random_ops(250, 45, 0);
  endtask

  task automatic test_zero_count();
    write_bucket_count(7'd0);
    run_random_ops(200, 55, 75);
  endtask

  task automatic test_rehash_with_keys();
    for (int p = 0; p < 3; p++) begin
      write_bucket_count(CNT_WIDTH_VAL($urandom_range(2, 40)));
      run_random_ops(100, 50, 35);
    end
  endtask

  task automatic test_random_counts();
    int idle_pct;
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 0) ? 0 : (p == 1) ? 75 : (p == 2) ? 35 : 0;
      write_bucket_count(CNT_WIDTH_VAL($urandom_range(1, 127)));
      run_random_ops(80, 50, idle_pct);
    end
  endtask

  // result checking
  always @(posedge clk) begin
    probe_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("unexpected result: status %0d comparisons %0d bucket %0d",
                   out_status, out_comparisons, out_bucket);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_comparisons !== want.comps ||
            out_bucket !== want.bucket) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("mismatch: got status %0d comparisons %0d bucket %0d, wanted %0d %0d %0d",
                     out_status, out_comparisons, out_bucket,
                     want.status, want.comps, want.bucket);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("chained_hash_table_probe_count test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_count_extremes();
    test_chain_overflow();
    test_wide_table();
    test_narrow_table();
    test_saturated_count();
    test_zero_count();
    test_rehash_with_keys();
    test_random_counts();
    wait_drained();
    repeat (100) @(posedge clk);
    $display("covered %0d inserts, %0d searches (%0d found, longest walk %0d), %0d clears, %0d other",
             action_cnt[ACT_INSERT], action_cnt[ACT_SEARCH], found_cnt, longest_walk,
             action_cnt[ACT_CLEAR], action_cnt[ACT_NONE]);
    $display("%0d inserts refused on full chains across %0d bucket count settings",
             full_cnt, count_writes + 1);
    if (mismatch_cnt == 0) begin
      $display("chained_hash_table_probe_count test passed");
    end else begin
      $display("chained_hash_table_probe_count test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/chtp_pkg.sv
hdl/chtp_mod.sv
hdl/chained_hash_table_probe_count.sv
tb/chained_hash_table_probe_count_tb.sv
